### rtl/core/mtsd_pkg.sv
package mtsd_pkg;

  localparam int unsigned BUTTON_W   = 16;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned TAPS_W     = 8;
  localparam int unsigned GAP_W      = 24;
  localparam int unsigned LOCK_W     = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned BUTTON_COUNT_DEF = 16;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 8'd2;
  localparam logic [TAPS_W-1:0] MIN_TAPS   = 8'd2;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 24'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_TAPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP_TICKS = 1'b1;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [BUTTON_W-1:0] buttons_now;
    logic [BUTTON_W-1:0] buttons_before;
    logic [INDEX_W-1:0]  button_index;
    logic [DELTA_W-1:0]  delta_ticks;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              completed;
    logic [TAPS_W-1:0] taps_so_far;
    logic              waiting;
  } out_item_t;

  typedef struct packed {
    logic              taps_we;
    logic              gap_we;
    logic [TAPS_W-1:0] taps;
    logic [GAP_W-1:0]  gap;
  } cfg_wr_t;

endpackage

### rtl/core/mtsd_cfg.sv
module mtsd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [mtsd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mtsd_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [mtsd_pkg::TAPS_W-1:0]     required_taps,
  output logic [mtsd_pkg::GAP_W-1:0]      max_gap_ticks,
  output mtsd_pkg::cfg_wr_t               wr_event
);
  import mtsd_pkg::*;

  logic [TAPS_W-1:0] required_taps_r;
  logic [GAP_W-1:0]  max_gap_ticks_r;
  logic [TAPS_W-1:0] taps_val;
  logic [GAP_W-1:0]  gap_val;

  // Writes with a tap count below the minimum or a zero window are dropped.
  assign taps_val = wr_data[TAPS_W-1:0];
  assign gap_val  = wr_data[GAP_W-1:0];

  always_comb begin
    wr_event.taps    = taps_val;
    wr_event.gap     = gap_val;
    wr_event.taps_we = wr_en && (wr_index == REG_REQUIRED_TAPS) && (taps_val >= MIN_TAPS);
    wr_event.gap_we  = wr_en && (wr_index == REG_MAX_GAP_TICKS) && (gap_val != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_taps_r <= TAPS_RESET;
      max_gap_ticks_r <= GAP_RESET;
    end else begin
      if (wr_event.taps_we) begin
        required_taps_r <= taps_val;
      end
      if (wr_event.gap_we) begin
        max_gap_ticks_r <= gap_val;
      end
    end
  end

  assign required_taps = required_taps_r;
  assign max_gap_ticks = max_gap_ticks_r;

endmodule

### rtl/core/mtsd_seq.sv
module mtsd_seq #(
  parameter int unsigned BUTTON_COUNT = mtsd_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  mtsd_pkg::in_item_t          item,
  input  logic [mtsd_pkg::TAPS_W-1:0] required_taps,
  input  logic [mtsd_pkg::GAP_W-1:0]  max_gap_ticks,
  input  mtsd_pkg::cfg_wr_t           cfg_wr,
  output mtsd_pkg::out_item_t         result
);
  import mtsd_pkg::*;

  localparam logic [LOCK_W-1:0] LOCK_NONE = LOCK_W'(BUTTON_COUNT);

  logic [TAPS_W-1:0] tap_count_r,  tap_count_nxt;
  logic [GAP_W-1:0]  gap_elapsed_r, gap_elapsed_nxt;
  logic [LOCK_W-1:0] locked_r,     locked_nxt;
  logic [TAPS_W-1:0] taps_need_r,  taps_need_nxt;
  logic [GAP_W-1:0]  gap_limit_r,  gap_limit_nxt;
  logic              done_r,       done_nxt;

  logic [GAP_W:0]    gap_sum;
  logic              idx_ok;
  logic              pressed;
  logic              accepted;

  assign gap_sum = {1'b0, gap_elapsed_r} + (GAP_W+1)'(item.delta_ticks);
  assign idx_ok  = LOCK_W'(item.button_index) < LOCK_W'(BUTTON_COUNT);
  assign pressed = item.buttons_now[item.button_index] &&
                   !item.buttons_before[item.button_index];

  always_comb begin
    tap_count_nxt   = tap_count_r;
    gap_elapsed_nxt = gap_elapsed_r;
    locked_nxt      = locked_r;
    taps_need_nxt   = taps_need_r;
    gap_limit_nxt   = gap_limit_r;
    done_nxt        = done_r;
    accepted        = 1'b1;

    if (item.mode == MODE_CLEAR) begin
      tap_count_nxt   = '0;
      gap_elapsed_nxt = '0;
      locked_nxt      = LOCK_NONE;
      taps_need_nxt   = required_taps;
      gap_limit_nxt   = max_gap_ticks;
      done_nxt        = 1'b0;
    end else if (!idx_ok ||
                 ((tap_count_r != '0) && (locked_r != LOCK_W'(item.button_index)))) begin
      accepted = 1'b0;
    end else begin
      done_nxt = 1'b0;
      // The gap advances first; an expired sequence clears before the tap is seen.
      if ((tap_count_r != '0) && (item.delta_ticks != '0)) begin
        if (gap_sum > {1'b0, gap_limit_r}) begin
          tap_count_nxt   = '0;
          gap_elapsed_nxt = '0;
          locked_nxt      = LOCK_NONE;
          taps_need_nxt   = required_taps;
          gap_limit_nxt   = max_gap_ticks;
        end else begin
          gap_elapsed_nxt = gap_sum[GAP_W-1:0];
        end
      end
      if (pressed) begin
        if (tap_count_nxt == '0) begin
          tap_count_nxt   = TAPS_W'(1);
          gap_elapsed_nxt = '0;
          locked_nxt      = LOCK_W'(item.button_index);
          taps_need_nxt   = required_taps;
          gap_limit_nxt   = max_gap_ticks;
        end else begin
          tap_count_nxt   = tap_count_nxt + TAPS_W'(1);
          gap_elapsed_nxt = '0;
        end
        if (tap_count_nxt >= taps_need_nxt) begin
          tap_count_nxt   = '0;
          gap_elapsed_nxt = '0;
          locked_nxt      = LOCK_NONE;
          taps_need_nxt   = required_taps;
          gap_limit_nxt   = max_gap_ticks;
          done_nxt        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r   <= '0;
      gap_elapsed_r <= '0;
      locked_r      <= LOCK_NONE;
      taps_need_r   <= TAPS_RESET;
      gap_limit_r   <= GAP_RESET;
      done_r        <= 1'b0;
    end else if (fire) begin
      tap_count_r   <= tap_count_nxt;
      gap_elapsed_r <= gap_elapsed_nxt;
      locked_r      <= locked_nxt;
      taps_need_r   <= taps_need_nxt;
      gap_limit_r   <= gap_limit_nxt;
      done_r        <= done_nxt;
    end else if (tap_count_r == '0) begin
      // With no sequence running and no item firing, register writes also reach the latched copies.
      if (cfg_wr.taps_we) begin
        taps_need_r <= cfg_wr.taps;
      end
      if (cfg_wr.gap_we) begin
        gap_limit_r <= cfg_wr.gap;
      end
    end
  end

  always_comb begin
    result.accepted    = accepted;
    result.completed   = done_nxt;
    result.taps_so_far = tap_count_nxt;
    result.waiting     = (tap_count_nxt != '0);
  end

endmodule

### rtl/core/mtsd_out_stage.sv
module mtsd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mtsd_pkg::out_item_t load_item,
  input  logic                stall,
  output logic                valid,
  output mtsd_pkg::out_item_t item,
  output logic                can_load
);
  import mtsd_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign can_load = !valid_r || !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      item_r <= load_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

### rtl/core/multi_tap_sequence_detector.sv
// Multi-tap sequence detector: counts taps (rising edges) on one watched
// button and flags when the configured number of taps arrives in time.
// Input channel: in_valid, in_stall and in_data carry one update item; an
// item is taken at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid, out_stall and out_data carry one result item
// for every input item, in order.
// Configuration: cfg_valid, cfg_ready, cfg_index and cfg_data write the tap
// count (index 0) or the gap window (index 1); cfg_ready is always high.
// Write configuration only while no item is in flight.
// A result is registered in the output stage when its item leaves the input
// register, and one item is taken every cycle while out_stall holds no
// result. The rate is set by the single registered pass over the sequence
// state, which holds the gap add and compare and the tap counter and compare.
// A synchronous reset on rst_n low empties both stages, sets the registers
// to their defaults and ends any running sequence.
// When out_stall holds a result, the item behind it waits in the input
// register and in_stall rises only once both stages are full.
module multi_tap_sequence_detector #(
  parameter int unsigned BUTTON_COUNT = mtsd_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mtsd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mtsd_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtsd_pkg::*;

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_can_load;
  logic              fire;
  logic [TAPS_W-1:0] required_taps;
  logic [GAP_W-1:0]  max_gap_ticks;
  cfg_wr_t           cfg_wr;
  out_item_t         result;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_valid_r && !out_can_load;
  assign fire      = in_valid_r && out_can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  mtsd_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (cfg_valid && cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .required_taps (required_taps),
    .max_gap_ticks (max_gap_ticks),
    .wr_event      (cfg_wr)
  );

  mtsd_seq #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (in_item_r),
    .required_taps (required_taps),
    .max_gap_ticks (max_gap_ticks),
    .cfg_wr        (cfg_wr),
    .result        (result)
  );

  mtsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_item (result),
    .stall     (out_stall),
    .valid     (out_valid),
    .item      (out_data),
    .can_load  (out_can_load)
  );

`ifndef SYNTHESIS
  a_waiting_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.waiting == (out_data.taps_so_far != '0)))
    else $error("waiting flag disagrees with tap count");

  a_completed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.completed) |-> (out_data.taps_so_far == '0))
    else $error("completed result still shows a running sequence");

  a_taps_reg_legal: assert property (@(posedge clk) disable iff (!rst_n)
    required_taps >= MIN_TAPS)
    else $error("tap count register below minimum");

  a_in_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result stage can move");
`endif

endmodule
